### src/dpb_pkg.sv
package dpb_pkg;

	localparam int DEPTH_W  = 16;
	localparam int PIX_W    = 10;
	localparam int COLOR_W  = 8;
	localparam int SCALE_W  = 24;
	localparam int CENTER_W = 16;
	localparam int Z_W      = 32;
	localparam int COORD_W  = 48;
	localparam int MAG_W    = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH_SCALE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_KEEP_INVALID = 3'd5;

	localparam logic [SCALE_W-1:0]  RST_DEPTH_SCALE = 24'd16777;
	localparam logic [CENTER_W-1:0] RST_CENTER_X    = 16'd2560;
	localparam logic [CENTER_W-1:0] RST_CENTER_Y    = 16'd1920;
	localparam logic [SCALE_W-1:0]  RST_INV_FOCAL   = 24'd31775;

	typedef struct packed {
		logic [DEPTH_W-1:0] depth;
		logic [PIX_W-1:0]   pixel_col;
		logic [PIX_W-1:0]   pixel_row;
		logic [COLOR_W-1:0] blue_in;
		logic [COLOR_W-1:0] green_in;
		logic [COLOR_W-1:0] red_in;
	} pixel_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic [Z_W-1:0]            point_z;
		logic [COLOR_W-1:0]        red_out;
		logic [COLOR_W-1:0]        green_out;
		logic [COLOR_W-1:0]        blue_out;
		logic                      point_valid;
		logic [PIX_W-1:0]          out_col;
		logic [PIX_W-1:0]          out_row;
	} point_t;

	// Load enables of the pipeline stages shared by the projection units.
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} adv_t;

	// Magnitude of (pix << 4) - center, with its sign.
	function automatic logic [MAG_W:0] offset_mag(input logic [PIX_W-1:0] pix,
			input logic [CENTER_W-1:0] center);
		logic signed [MAG_W:0] d;
		logic [MAG_W:0] m;
		d = signed'(17'({pix, 4'b0000})) - signed'(17'(center));
		m = d[MAG_W] ? 17'(-d) : 17'(d);
		return {d[MAG_W], m[MAG_W-1:0]};
	endfunction

endpackage

### src/dpb_proj.sv
module dpb_proj (
	input  logic                                 clk,
	input  dpb_pkg::adv_t                        adv,
	input  logic [dpb_pkg::Z_W-1:0]              z,
	input  logic                                 neg,
	input  logic [dpb_pkg::MAG_W-1:0]            mag,
	input  logic [dpb_pkg::SCALE_W-1:0]          inv,
	output logic signed [dpb_pkg::COORD_W-1:0]   coord
);
	import dpb_pkg::*;

	localparam int A_W = Z_W + MAG_W;
	localparam int H_W = A_W - SCALE_W;
	localparam int P_W = A_W + SCALE_W;

	logic [A_W-1:0]             a_s2;
	logic                       neg_s2, neg_s3, neg_s4;
	logic [H_W+SCALE_W-1:0]     hi_s3;
	logic [2*SCALE_W-1:0]       lo_s3;
	logic [P_W-1:0]             p_s4;
	logic signed [P_W:0]        sp;
	logic signed [COORD_W-1:0]  coord_s5;

	// Full product p is split into two 24-bit halves of a; the floor of
	// -p / 2^28 comes out of the arithmetic shift of the negated product.
	assign sp = neg_s4 ? -signed'({1'b0, p_s4}) : signed'({1'b0, p_s4});

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			a_s2   <= A_W'(z * mag);
			neg_s2 <= neg;
		end
		if (adv.s3) begin
			hi_s3  <= (H_W+SCALE_W)'(a_s2[A_W-1:SCALE_W] * inv);
			lo_s3  <= (2*SCALE_W)'(a_s2[SCALE_W-1:0] * inv);
			neg_s3 <= neg_s2;
		end
		if (adv.s4) begin
			p_s4   <= {hi_s3, {SCALE_W{1'b0}}} + P_W'(lo_s3);
			neg_s4 <= neg_s3;
		end
		if (adv.s5) begin
			coord_s5 <= COORD_W'(sp >>> 28);
		end
	end

	assign coord = coord_s5;

endmodule

### src/depth_pixel_backprojection_top.sv
// Each accepted pixel is registered through stages s1 to s5 before out_valid rises.
// Throughput: one pixel per cycle while out_ready is high, through a five-stage pipeline whose stages
// advance independently, so bubbles collapse while the output is stalled.
// Zero-depth pixels with keep_invalid cleared and pixels outside the frame
// are dropped at the input and take no pipeline slot.
// Reset (arst_n low) empties the pipeline and loads the default camera registers.
module depth_pixel_backprojection_top #(
	parameter int MAX_COLS = 1024,
	parameter int MAX_ROWS = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [dpb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dpb_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  dpb_pkg::pixel_t                   pixel,
	output logic                              out_valid,
	input  logic                              out_ready,
	output dpb_pkg::point_t                   point
);
	import dpb_pkg::*;

	typedef struct packed {
		logic [Z_W-1:0]     z;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic               pv;
		logic [PIX_W-1:0]   col;
		logic [PIX_W-1:0]   row;
	} side_t;

	logic [SCALE_W-1:0]  depth_scale_q, inv_focal_x_q, inv_focal_y_q;
	logic [CENTER_W-1:0] center_x_q, center_y_q;
	logic                keep_invalid_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	adv_t adv;

	side_t side_s1, side_s2, side_s3, side_s4, side_s5;
	logic  negx_s1, negy_s1;
	logic [MAG_W-1:0] magx_s1, magy_s1;
	logic [MAG_W:0]   offx, offy;
	logic             in_frame, emit;
	logic [DEPTH_W+SCALE_W-1:0] range_prod;
	logic signed [COORD_W-1:0] x_s5, y_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_scale_q  <= RST_DEPTH_SCALE;
			center_x_q     <= RST_CENTER_X;
			center_y_q     <= RST_CENTER_Y;
			inv_focal_x_q  <= RST_INV_FOCAL;
			inv_focal_y_q  <= RST_INV_FOCAL;
			keep_invalid_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEPTH_SCALE:  depth_scale_q  <= cfg_data[SCALE_W-1:0];
				REG_CENTER_X:     center_x_q     <= cfg_data[CENTER_W-1:0];
				REG_CENTER_Y:     center_y_q     <= cfg_data[CENTER_W-1:0];
				REG_INV_FOCAL_X:  inv_focal_x_q  <= cfg_data[SCALE_W-1:0];
				REG_INV_FOCAL_Y:  inv_focal_y_q  <= cfg_data[SCALE_W-1:0];
				REG_KEEP_INVALID: keep_invalid_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Each stage loads when it is empty or the stage after it moves on.
	assign rdy5 = !v_s5 || out_ready;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_ready = rdy1;
	assign adv = '{s2: rdy2, s3: rdy3, s4: rdy4, s5: rdy5};

	assign in_frame = (32'(pixel.pixel_col) < 32'(MAX_COLS))
		&& (32'(pixel.pixel_row) < 32'(MAX_ROWS));
	assign emit = in_frame && ((pixel.depth != '0) || keep_invalid_q);
	assign offx = offset_mag(pixel.pixel_col, center_x_q);
	assign offy = offset_mag(pixel.pixel_row, center_y_q);
	assign range_prod = pixel.depth * depth_scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid && emit;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// A zero depth gives z = 0, which carries zero coordinates through.
	always_ff @(posedge clk) begin
		if (rdy1) begin
			side_s1.z     <= range_prod[DEPTH_W+SCALE_W-1:8];
			side_s1.red   <= pixel.red_in;
			side_s1.green <= pixel.green_in;
			side_s1.blue  <= pixel.blue_in;
			side_s1.pv    <= pixel.depth != '0;
			side_s1.col   <= pixel.pixel_col;
			side_s1.row   <= pixel.pixel_row;
			negx_s1       <= offx[MAG_W];
			magx_s1       <= offx[MAG_W-1:0];
			negy_s1       <= offy[MAG_W];
			magy_s1       <= offy[MAG_W-1:0];
		end
		if (rdy2) side_s2 <= side_s1;
		if (rdy3) side_s3 <= side_s2;
		if (rdy4) side_s4 <= side_s3;
		if (rdy5) side_s5 <= side_s4;
	end

	dpb_proj u_proj_x (
		.clk    (clk),
		.adv    (adv),
		.z      (side_s1.z),
		.neg    (negx_s1),
		.mag    (magx_s1),
		.inv    (inv_focal_x_q),
		.coord  (x_s5)
	);

	dpb_proj u_proj_y (
		.clk    (clk),
		.adv    (adv),
		.z      (side_s1.z),
		.neg    (negy_s1),
		.mag    (magy_s1),
		.inv    (inv_focal_y_q),
		.coord  (y_s5)
	);

	assign out_valid         = v_s5;
	assign point.point_x     = x_s5;
	assign point.point_y     = y_s5;
	assign point.point_z     = side_s5.z;
	assign point.red_out     = side_s5.red;
	assign point.green_out   = side_s5.green;
	assign point.blue_out    = side_s5.blue;
	assign point.point_valid = side_s5.pv;
	assign point.out_col     = side_s5.col;
	assign point.out_row     = side_s5.row;

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !point.point_valid |->
			point.point_x == '0 && point.point_y == '0 && point.point_z == '0)
		else $error("invalid point with nonzero coordinates");

	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && pixel.depth == '0 && !keep_invalid_q |=> !v_s1)
		else $error("zero-depth pixel entered the pipeline in drop mode");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && !out_ready)
		else $error("input stalled while the pipeline has a bubble");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !rdy4 |=> v_s4)
		else $error("stalled stage lost its beat");

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
	import dpb_pkg::*;

	localparam int FRAME_COLS    = 1024;
	localparam int FRAME_ROWS    = 1024;
	localparam int NUM_PHASES    = 10;
	localparam int PHASE_ITEMS   = 103;
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT   = 200000;

	// Indexes past the register list; writes there must have no effect.
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_B = 3'd7;

	typedef struct packed {
		logic [SCALE_W-1:0]  scale;
		logic [CENTER_W-1:0] cx;
		logic [CENTER_W-1:0] cy;
		logic [SCALE_W-1:0]  ifx;
		logic [SCALE_W-1:0]  ify;
		logic                keep;
	} camera_t;

	typedef struct packed {
		pixel_t px;
		logic   typed;
		point_t want;
	} vector_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	pixel_t                pixel = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	point_t                point;

	// Camera registers as the block should hold them.
	logic [SCALE_W-1:0]  cam_scale;
	logic [CENTER_W-1:0] cam_cx;
	logic [CENTER_W-1:0] cam_cy;
	logic [SCALE_W-1:0]  cam_ifx;
	logic [SCALE_W-1:0]  cam_ify;
	logic                cam_keep;

	point_t  expected_points[$];
	point_t  expected_front;
	vector_t directed_rows[$];
	int      mismatch_count = 0;
	int      cycles = 0;
	bit      no_idle = 1'b0;

	depth_pixel_backprojection_top #(
		.MAX_COLS(FRAME_COLS),
		.MAX_ROWS(FRAME_ROWS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pixel(pixel),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.point(point)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("depth_pixel_backprojection_top: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= no_idle || ($urandom_range(99) >= 8);
	end

	function automatic pixel_t mk_pixel(input logic [DEPTH_W-1:0] depth,
			input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row,
			input logic [COLOR_W-1:0] b, input logic [COLOR_W-1:0] g,
			input logic [COLOR_W-1:0] r);
		return '{depth: depth, pixel_col: col, pixel_row: row,
			blue_in: b, green_in: g, red_in: r};
	endfunction

	function automatic point_t mk_point(input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y, input logic [Z_W-1:0] z,
			input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
			input logic [COLOR_W-1:0] b, input logic valid,
			input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row);
		return '{point_x: x, point_y: y, point_z: z, red_out: r, green_out: g,
			blue_out: b, point_valid: valid, out_col: col, out_row: row};
	endfunction

	// Z * ((pix << 4) - center) * inv, shifted down by 28 with floor rounding.
	function automatic logic [COORD_W-1:0] project_axis(input logic [Z_W-1:0] z,
			input logic [PIX_W-1:0] pix, input logic [CENTER_W-1:0] center,
			input logic [SCALE_W-1:0] inv);
		logic signed [16:0] offs;
		logic signed [79:0] prod;
		offs = $signed({3'b000, pix, 4'b0000}) - $signed({1'b0, center});
		prod = $signed({48'd0, z}) * offs * $signed({56'd0, inv});
		prod = prod >>> 28;
		return prod[COORD_W-1:0];
	endfunction

	function automatic bit backproject(input pixel_t px, output point_t pt);
		logic [39:0] range_prod;
		logic [Z_W-1:0] z;
		pt = '0;
		if (int'(px.pixel_col) >= FRAME_COLS || int'(px.pixel_row) >= FRAME_ROWS)
			return 1'b0;
		if (px.depth == '0 && !cam_keep)
			return 1'b0;
		if (px.depth != '0) begin
			range_prod = {24'd0, px.depth} * {16'd0, cam_scale};
			z = range_prod[39:8];
			pt.point_x = project_axis(z, px.pixel_col, cam_cx, cam_ifx);
			pt.point_y = project_axis(z, px.pixel_row, cam_cy, cam_ify);
			pt.point_z = z;
			pt.point_valid = 1'b1;
		end
		pt.red_out = px.red_in;
		pt.green_out = px.green_in;
		pt.blue_out = px.blue_in;
		pt.out_col = px.pixel_col;
		pt.out_row = px.pixel_row;
		return 1'b1;
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t px;
		int sel;
		px = pixel_t'(60'({$urandom, $urandom}));
		sel = $urandom_range(99);
		if (sel < 10)
			px.depth = '0;
		else if (sel < 15)
			px.depth = '1;
		else if (sel < 18)
			px.depth = 16'd1;
		sel = $urandom_range(99);
		if (sel < 8)
			px.pixel_col = '0;
		else if (sel < 16)
			px.pixel_col = '1;
		else if (sel < 30)
			px.pixel_col = 10'(cam_cx[15:4]) + 10'($urandom_range(4)) - 10'd2;
		sel = $urandom_range(99);
		if (sel < 8)
			px.pixel_row = '0;
		else if (sel < 16)
			px.pixel_row = '1;
		else if (sel < 30)
			px.pixel_row = 10'(cam_cy[15:4]) + 10'($urandom_range(4)) - 10'd2;
		return px;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic add_expected(input point_t p);
		expected_points.insert(expected_points.size(), p);
	endtask

	task automatic add_row(input vector_t r);
		directed_rows.insert(directed_rows.size(), r);
	endtask

	task automatic check_field(input string name, input logic [COORD_W-1:0] got,
			input logic [COORD_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h want %h (col %0d row %0d)", name, got,
				want, expected_front.out_col, expected_front.out_row));
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_points.size() == 0) begin
				report_mismatch($sformatf("point beat with nothing pending, col %0d row %0d",
					point.out_col, point.out_row));
			end else begin
				expected_front = expected_points.pop_front();
				check_field("point_x", point.point_x, expected_front.point_x);
				check_field("point_y", point.point_y, expected_front.point_y);
				check_field("point_z", 48'(point.point_z), 48'(expected_front.point_z));
				check_field("red_out", 48'(point.red_out), 48'(expected_front.red_out));
				check_field("green_out", 48'(point.green_out), 48'(expected_front.green_out));
				check_field("blue_out", 48'(point.blue_out), 48'(expected_front.blue_out));
				check_field("point_valid", 48'(point.point_valid),
					48'(expected_front.point_valid));
				check_field("out_col", 48'(point.out_col), 48'(expected_front.out_col));
				check_field("out_row", 48'(point.out_row), 48'(expected_front.out_row));
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_DEPTH_SCALE:  cam_scale = data[SCALE_W-1:0];
			REG_CENTER_X:     cam_cx = data[CENTER_W-1:0];
			REG_CENTER_Y:     cam_cy = data[CENTER_W-1:0];
			REG_INV_FOCAL_X:  cam_ifx = data[SCALE_W-1:0];
			REG_INV_FOCAL_Y:  cam_ify = data[SCALE_W-1:0];
			REG_KEEP_INVALID: cam_keep = data[0];
			default: ;
		endcase
	endtask

	task automatic load_camera(input camera_t c);
		// Narrow registers get junk in the unused upper data bits.
		write_reg(REG_DEPTH_SCALE, c.scale);
		write_reg(REG_CENTER_X, {8'($urandom), c.cx});
		write_reg(REG_CENTER_Y, {8'($urandom), c.cy});
		write_reg(REG_INV_FOCAL_X, c.ifx);
		write_reg(REG_INV_FOCAL_Y, c.ify);
		write_reg(REG_KEEP_INVALID, {23'($urandom), c.keep});
		write_reg(REG_UNMAPPED_A, 24'($urandom));
		write_reg(REG_UNMAPPED_B, 24'($urandom));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Returns at the edge where the beat is taken; valid is left high.
	task automatic send_pixel(input pixel_t px);
		while (!no_idle && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pixel <= px;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic wait_drained();
		while (expected_points.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		camera_t cam;
		point_t pt;
		pixel_t px;

		cam_scale = RST_DEPTH_SCALE;
		cam_cx = RST_CENTER_X;
		cam_cy = RST_CENTER_Y;
		cam_ifx = RST_INV_FOCAL;
		cam_ify = RST_INV_FOCAL;
		cam_keep = 1'b1;

		// Typed rows assume the reset camera: center at column 160, row 120.
		add_row({mk_pixel(16'd0, 10'd0, 10'd0, 8'h00, 8'h00, 8'h00),
			1'b1, mk_point('0, '0, '0, 8'h00, 8'h00, 8'h00, 1'b0, 10'd0, 10'd0)});
		add_row({mk_pixel(16'd0, 10'd1023, 10'd1023, 8'hFF, 8'hFF, 8'hFF),
			1'b1, mk_point('0, '0, '0, 8'hFF, 8'hFF, 8'hFF, 1'b0, 10'd1023, 10'd1023)});
		add_row({mk_pixel(16'd0, 10'd341, 10'd682, 8'h12, 8'h34, 8'h56),
			1'b1, mk_point('0, '0, '0, 8'h56, 8'h34, 8'h12, 1'b0, 10'd341, 10'd682)});
		add_row({mk_pixel(16'd256, 10'd160, 10'd120, 8'h01, 8'h02, 8'h03),
			1'b1, mk_point('0, '0, 32'd16777, 8'h03, 8'h02, 8'h01, 1'b1, 10'd160, 10'd120)});
		add_row({mk_pixel(16'hFFFF, 10'd160, 10'd120, 8'hA5, 8'h5A, 8'hC3),
			1'b1, mk_point('0, '0, 32'd4294846, 8'hC3, 8'h5A, 8'hA5, 1'b1, 10'd160, 10'd120)});
		add_row({mk_pixel(16'd1, 10'd160, 10'd120, 8'h00, 8'h00, 8'h00),
			1'b1, mk_point('0, '0, 32'd65, 8'h00, 8'h00, 8'h00, 1'b1, 10'd160, 10'd120)});
		add_row({mk_pixel(16'd1, 10'd0, 10'd0, 8'h11, 8'h22, 8'h33),
			1'b0, point_t'('0)});
		add_row({mk_pixel(16'hFFFF, 10'd0, 10'd0, 8'h00, 8'hFF, 8'h00),
			1'b0, point_t'('0)});
		add_row({mk_pixel(16'hFFFF, 10'd1023, 10'd1023, 8'hFF, 8'h00, 8'hFF),
			1'b0, point_t'('0)});
		add_row({mk_pixel(16'hFFFF, 10'd0, 10'd1023, 8'h0F, 8'hF0, 8'h3C),
			1'b0, point_t'('0)});
		add_row({mk_pixel(16'hFFFF, 10'd1023, 10'd0, 8'hF0, 8'h0F, 8'hC3),
			1'b0, point_t'('0)});
		add_row({mk_pixel(16'h8000, 10'h200, 10'h200, 8'h80, 8'h80, 8'h80),
			1'b0, point_t'('0)});
		add_row({mk_pixel(16'h5555, 10'h155, 10'h2AA, 8'h55, 8'hAA, 8'h55),
			1'b0, point_t'('0)});
		add_row({mk_pixel(16'hAAAA, 10'h2AA, 10'h155, 8'hAA, 8'h55, 8'hAA),
			1'b0, point_t'('0)});
		add_row({mk_pixel(16'd1, 10'd161, 10'd119, 8'h01, 8'h01, 8'h01),
			1'b0, point_t'('0)});
		add_row({mk_pixel(16'd2, 10'd159, 10'd121, 8'h02, 8'h02, 8'h02),
			1'b0, point_t'('0)});
		add_row({mk_pixel(16'hFFFF, 10'd160, 10'd0, 8'h7F, 8'h7F, 8'h7F),
			1'b0, point_t'('0)});

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_pixel(directed_rows[i].px);
			if (directed_rows[i].typed)
				add_expected(directed_rows[i].want);
			else if (backproject(directed_rows[i].px, pt))
				add_expected(pt);
		end
		in_valid <= 1'b0;
		wait_drained();

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: cam = '{'1, '1, '1, '1, '1, 1'b0};
				1: cam = '{'0, '0, '0, '0, '0, 1'b1};
				2: cam = '{'1, '0, '0, '1, '1, 1'b1};
				3: cam = '{RST_DEPTH_SCALE, RST_CENTER_X, RST_CENTER_Y, RST_INV_FOCAL,
					RST_INV_FOCAL, 1'b0};
				4: cam = '{RST_DEPTH_SCALE, 16'd5120, 16'd3840, RST_INV_FOCAL,
					RST_INV_FOCAL, 1'b1};
				default: cam = '{24'($urandom), 16'($urandom), 16'($urandom),
					24'($urandom), 24'($urandom), 1'($urandom)};
			endcase
			load_camera(cam);
			// One phase runs with both sides streaming back to back.
			no_idle = (phase == 4);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				px = random_pixel();
				send_pixel(px);
				if (backproject(px, pt))
					add_expected(pt);
			end
			in_valid <= 1'b0;
			no_idle = 1'b0;
			wait_drained();
		end

		if (mismatch_count == 0)
			$display("depth_pixel_backprojection_top: match");
		else
			$display("depth_pixel_backprojection_top: mismatch");
		$finish;
	end

endmodule
